>>> hw/rtl/tmsc_pkg.sv
// ----------------------------------------------------------------------------
// tmsc_pkg: shared types and constants for the tacho median speed controller
// Register indexes, field widths, reset values and the front-to-back command.
// ----------------------------------------------------------------------------
package tmsc_pkg;

  localparam int unsigned SPEED_W   = 20;
  localparam int unsigned GAIN_W    = 32;
  localparam int unsigned SETPT_W   = 20;
  localparam int unsigned KP_W      = 12;
  localparam int unsigned DRIVE_W   = 16;
  localparam int unsigned LIMIT_W   = 20;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
  localparam logic [DRIVE_W-1:0] DRIVE_RST = 16'd2560;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SETPOINT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_LIMIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_PERIOD = 3'd5;

  typedef struct packed {
    logic [GAIN_W-1:0]   speed_gain;
    logic [SETPT_W-1:0]  speed_setpoint;
    logic [KP_W-1:0]     prop_gain;
    logic [DRIVE_W-1:0]  drive_max;
    logic [LIMIT_W-1:0]  stall_limit;
    logic [PERIOD_W-1:0] control_period;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    speed_gain:     32'd25600000,
    speed_setpoint: 20'd2560,
    prop_gain:      12'd154,
    drive_max:      16'd20480,
    stall_limit:    20'd50000,
    control_period: 16'd10000
  };

  // classification of one item, handed from front to back
  typedef struct packed {
    logic is_edge;
    logic run_ctrl;
    logic stalled;
  } cmd_t;

  localparam int unsigned CMD_W = $bits(cmd_t);

endpackage

>>> hw/rtl/tacho_median_speed_p_control.sv
// ----------------------------------------------------------------------------
// tacho_median_speed_p_control: tachometer median speed meter with P control
// Per-tick front classifier, command queue, and a back end with a serial
// divider and proportional drive update.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  input    | push / full            | tach_level_i
//  result   | empty / pop            | speed_value_o, drive_level_o,
//           |                        | drive_updated_o, edge_seen_o
//  config   | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
//  Back end runs each item through idle, control and emit, plus an add state
//  for a controller update and a divide state for a rising edge's division.
//  The front takes an item every cycle until the command queue is full.
//  Reset is asynchronous and clears the window, counters and drive to their
//  start values; no clearing pass is needed. Config writes are always ready.
// ----------------------------------------------------------------------------
module tacho_median_speed_p_control #(
  parameter int unsigned WINDOW_LEN  = 5,
  parameter int unsigned COUNT_WIDTH = 20,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic                            tach_level_i,
  input  logic                            pop,
  output logic                            empty,
  output logic [tmsc_pkg::SPEED_W-1:0]    speed_value_o,
  output logic [tmsc_pkg::LEVEL_W-1:0]    drive_level_o,
  output logic                            drive_updated_o,
  output logic                            edge_seen_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tmsc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tmsc_pkg::CFG_DAT_W-1:0]  cfg_data_i
);

  localparam int unsigned QW = tmsc_pkg::CMD_W + COUNT_WIDTH;

  tmsc_pkg::cfg_t         cfg_q;
  logic                   in_acc;
  tmsc_pkg::cmd_t         f_cmd, b_cmd;
  logic [COUNT_WIDTH-1:0] f_med;
  logic [QW-1:0]          q_out;
  logic                   q_empty, q_pop;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= tmsc_pkg::CFG_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        tmsc_pkg::REG_SPEED_GAIN: begin
          cfg_q.speed_gain <= cfg_data_i[tmsc_pkg::GAIN_W-1:0];
        end
        tmsc_pkg::REG_SPEED_SETPOINT: begin
          cfg_q.speed_setpoint <= cfg_data_i[tmsc_pkg::SETPT_W-1:0];
        end
        tmsc_pkg::REG_PROP_GAIN: begin
          cfg_q.prop_gain <= cfg_data_i[tmsc_pkg::KP_W-1:0];
        end
        tmsc_pkg::REG_DRIVE_MAX: begin
          cfg_q.drive_max <= cfg_data_i[tmsc_pkg::DRIVE_W-1:0];
        end
        tmsc_pkg::REG_STALL_LIMIT: begin
          cfg_q.stall_limit <= cfg_data_i[tmsc_pkg::LIMIT_W-1:0];
        end
        tmsc_pkg::REG_CONTROL_PERIOD: begin
          cfg_q.control_period <= cfg_data_i[tmsc_pkg::PERIOD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  tmsc_front #(
    .WINDOW_LEN  (WINDOW_LEN),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (in_acc),
    .tach_level_i     (tach_level_i),
    .stall_limit_i    (cfg_q.stall_limit),
    .control_period_i (cfg_q.control_period),
    .cmd_o            (f_cmd),
    .median_o         (f_med)
  );

  tmsc_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_acc),
    .data_i  ({f_cmd, f_med}),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  assign b_cmd = tmsc_pkg::cmd_t'(q_out[QW-1:COUNT_WIDTH]);

  tmsc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_valid_i     (!q_empty),
    .cmd_i           (b_cmd),
    .median_i        (q_out[COUNT_WIDTH-1:0]),
    .cmd_pop_o       (q_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .speed_value_o   (speed_value_o),
    .drive_level_o   (drive_level_o),
    .drive_updated_o (drive_updated_o),
    .edge_seen_o     (edge_seen_o)
  );

endmodule

>>> hw/rtl/tmsc_fifo.sv
// ----------------------------------------------------------------------------
// tmsc_fifo: small command queue
// Register-based FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module tmsc_fifo #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/tmsc_div.sv
// ----------------------------------------------------------------------------
// tmsc_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, 32-bit dividend.
// ----------------------------------------------------------------------------
module tmsc_div #(
  parameter int unsigned COUNT_WIDTH = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tmsc_pkg::GAIN_W-1:0] dividend_i,
  input  logic [COUNT_WIDTH-1:0]      divisor_i,
  output logic                        done_o,
  output logic [tmsc_pkg::GAIN_W-1:0] quotient_o
);

  localparam int unsigned QW    = tmsc_pkg::GAIN_W;
  localparam int unsigned STEP_W = $clog2(QW);

  logic                   busy_q, done_q;
  logic [STEP_W-1:0]      step_q;
  logic [COUNT_WIDTH:0]   rem_q;
  logic [QW-1:0]          quo_q;
  logic [COUNT_WIDTH-1:0] dsr_q;
  logic [COUNT_WIDTH:0]   rem_sh, rem_sub;
  logic                   fits;

  always_comb begin
    rem_sh  = {rem_q[COUNT_WIDTH-1:0], quo_q[QW-1]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    fits    = (rem_sh >= {1'b0, dsr_q});
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend bits shift out of the top of quo_q as quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub : rem_sh;
      quo_q <= {quo_q[QW-2:0], fits};
    end
  end

endmodule

>>> hw/rtl/tmsc_front.sv
// ----------------------------------------------------------------------------
// tmsc_front: tick classifier
// Edge detect, period count, median window and control timer; emits one
// command per item.
// ----------------------------------------------------------------------------
module tmsc_front #(
  parameter int unsigned WINDOW_LEN  = 5,
  parameter int unsigned COUNT_WIDTH = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          tach_level_i,
  input  logic [tmsc_pkg::LIMIT_W-1:0]  stall_limit_i,
  input  logic [tmsc_pkg::PERIOD_W-1:0] control_period_i,
  output tmsc_pkg::cmd_t                cmd_o,
  output logic [COUNT_WIDTH-1:0]        median_o
);

  localparam int unsigned RANK_W = $clog2(WINDOW_LEN);
  localparam int unsigned MID    = WINDOW_LEN / 2;
  localparam int unsigned CMP_W  = 33;
  localparam int unsigned PW     = tmsc_pkg::PERIOD_W;

  logic                   last_q;
  logic [COUNT_WIDTH-1:0] tick_q, tick_d, tick_base;
  logic [COUNT_WIDTH-1:0] win_q [WINDOW_LEN];
  logic [COUNT_WIDTH-1:0] win_sh [WINDOW_LEN];
  logic [RANK_W-1:0]      rank [WINDOW_LEN];
  logic [COUNT_WIDTH-1:0] med;
  logic [PW-1:0]          timer_q, timer_d;
  logic [PW:0]            timer_inc;
  logic                   is_edge;

  assign is_edge = !last_q && tach_level_i;

  always_comb begin
    tick_base = is_edge ? '0 : tick_q;
    tick_d    = (&tick_base) ? tick_base : tick_base + COUNT_WIDTH'(1);
    timer_inc = {1'b0, timer_q} + (PW + 1)'(1);
    timer_d   = (timer_inc >= {1'b0, control_period_i}) ? '0 : timer_inc[PW-1:0];
  end

  // window after the shift; the median is picked by stable rank
  always_comb begin
    med = '0;
    for (int i = 0; i < WINDOW_LEN - 1; i++) begin
      win_sh[i] = win_q[i + 1];
    end
    win_sh[WINDOW_LEN - 1] = tick_q;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW_LEN; j++) begin
        if ((win_sh[j] < win_sh[i]) || (j < i && win_sh[j] == win_sh[i])) begin
          rank[i] = rank[i] + RANK_W'(1);
        end
      end
      if (rank[i] == RANK_W'(MID)) begin
        med = med | win_sh[i];
      end
    end
  end

  assign median_o       = med;
  assign cmd_o.is_edge  = is_edge;
  assign cmd_o.run_ctrl = (timer_q == '0);
  assign cmd_o.stalled  = (CMP_W'(tick_d) > CMP_W'(stall_limit_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= 1'b1;
      tick_q  <= '0;
      timer_q <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_q[i] <= '0;
      end
    end else if (accept_i) begin
      last_q  <= tach_level_i;
      tick_q  <= tick_d;
      timer_q <= timer_d;
      if (is_edge) begin
        for (int i = 0; i < WINDOW_LEN; i++) begin
          win_q[i] <= win_sh[i];
        end
      end
    end
  end

endmodule

>>> hw/rtl/tmsc_back.sv
// ----------------------------------------------------------------------------
// tmsc_back: speed and drive update
// Runs the speed division on rising edges with a nonzero median and the
// proportional step when due, and holds the result register.
// ----------------------------------------------------------------------------
module tmsc_back #(
  parameter int unsigned COUNT_WIDTH = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tmsc_pkg::cfg_t                cfg_i,
  input  logic                          cmd_valid_i,
  input  tmsc_pkg::cmd_t                cmd_i,
  input  logic [COUNT_WIDTH-1:0]        median_i,
  output logic                          cmd_pop_o,
  input  logic                          pop_i,
  output logic                          empty_o,
  output logic [tmsc_pkg::SPEED_W-1:0]  speed_value_o,
  output logic [tmsc_pkg::LEVEL_W-1:0]  drive_level_o,
  output logic                          drive_updated_o,
  output logic                          edge_seen_o
);

  localparam int unsigned SW = tmsc_pkg::SPEED_W;
  localparam int unsigned DW = tmsc_pkg::DRIVE_W;
  localparam int unsigned QW = tmsc_pkg::GAIN_W;
  localparam int unsigned PRW = 34;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CTRL,
    ST_ADD,
    ST_EMIT
  } state_e;

  state_e          state_q;
  tmsc_pkg::cmd_t  cmd_q;
  logic [SW-1:0]   speed_q;
  logic [DW-1:0]   drive_q;
  logic signed [PRW-1:0] prod_q;
  logic            out_valid_q;

  logic            div_start, div_done;
  logic            emit;
  logic [QW-1:0]   quot;
  logic [SW-1:0]   quot_sat, spd_eff;
  logic signed [SW:0]      err;
  logic signed [tmsc_pkg::KP_W:0] kp_s;
  logic signed [PRW-1:0]   drv_s, drv_max_s, drv_sum;
  logic [DW-1:0]   drive_new;

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign div_start = cmd_pop_o && cmd_i.is_edge && (median_i != '0);
  assign empty_o   = !out_valid_q;
  // result slot is free, or its item leaves at this edge
  assign emit      = (state_q == ST_EMIT) && (!out_valid_q || pop_i);

  tmsc_div #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cfg_i.speed_gain),
    .divisor_i  (median_i),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  always_comb begin
    quot_sat  = (quot[QW-1:SW] != '0) ? tmsc_pkg::SPEED_MAX : quot[SW-1:0];
    spd_eff   = cmd_q.stalled ? '0 : speed_q;
    err       = $signed({1'b0, cfg_i.speed_setpoint}) - $signed({1'b0, spd_eff});
    kp_s      = $signed({1'b0, cfg_i.prop_gain});
    drv_s     = $signed(PRW'(drive_q));
    drv_max_s = $signed(PRW'(cfg_i.drive_max));
    // arithmetic shift floors, i.e. rounds toward minus infinity
    drv_sum   = drv_s + (prod_q >>> 8);
    if (drv_sum < 0) begin
      drive_new = '0;
    end else if (drv_sum > drv_max_s) begin
      drive_new = cfg_i.drive_max;
    end else begin
      drive_new = drv_sum[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      cmd_q           <= '0;
      speed_q         <= '0;
      drive_q         <= tmsc_pkg::DRIVE_RST;
      prod_q          <= '0;
      out_valid_q     <= 1'b0;
      speed_value_o   <= '0;
      drive_level_o   <= '0;
      drive_updated_o <= 1'b0;
      edge_seen_o     <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            if (div_start) begin
              state_q <= ST_DIV;
            end else begin
              if (cmd_i.is_edge) begin
                speed_q <= '0;
              end
              state_q <= ST_CTRL;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            speed_q <= quot_sat;
            state_q <= ST_CTRL;
          end
        end
        ST_CTRL: begin
          if (cmd_q.run_ctrl) begin
            speed_q <= spd_eff;
            prod_q  <= kp_s * err;
            state_q <= ST_ADD;
          end else begin
            state_q <= ST_EMIT;
          end
        end
        ST_ADD: begin
          drive_q <= drive_new;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit) begin
            speed_value_o   <= speed_q;
            drive_level_o   <= drive_q[DW-1:DW-tmsc_pkg::LEVEL_W];
            drive_updated_o <= cmd_q.run_ctrl;
            edge_seen_o     <= cmd_q.is_edge;
            state_q         <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> tb/sv/tb_tacho_median_speed_p_control.sv
// ----------------------------------------------------------------------------
// tb_tacho_median_speed_p_control: self-checking bench for the tacho speed loop
// Sends tachometer ticks through the push/full queue and predicts every tick
// result: median-of-five period speed and P-controlled drive. Registers are
// reprogrammed between phases; both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tacho_median_speed_p_control;

  localparam int WIN           = 5;
  localparam int CNT_W         = 20;
  localparam int SETTLE_CYCLES = 64;
  localparam int QUIET_LIMIT   = 2000;

  localparam int SPEED_W   = tmsc_pkg::SPEED_W;
  localparam int LEVEL_W   = tmsc_pkg::LEVEL_W;
  localparam int DRIVE_W   = tmsc_pkg::DRIVE_W;
  localparam int PERIOD_W  = tmsc_pkg::PERIOD_W;
  localparam int GAIN_W    = tmsc_pkg::GAIN_W;
  localparam int SETPT_W   = tmsc_pkg::SETPT_W;
  localparam int KP_W      = tmsc_pkg::KP_W;
  localparam int LIMIT_W   = tmsc_pkg::LIMIT_W;
  localparam int CFG_IDX_W = tmsc_pkg::CFG_IDX_W;
  localparam int CFG_DAT_W = tmsc_pkg::CFG_DAT_W;

  localparam logic [CNT_W-1:0]     CNT_MAX     = '1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct {
    logic [SPEED_W-1:0] speed;
    logic [LEVEL_W-1:0] drive_lvl;
    logic               updated;
    logic               rising;
  } tick_reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic tach_level = 1'b0;
  logic pop = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  logic full, empty, drive_updated, edge_seen, cfg_ready;
  logic [SPEED_W-1:0] speed_value;
  logic [LEVEL_W-1:0] drive_level;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  // shadow of the block
  tmsc_pkg::cfg_t    shadow_cfg = tmsc_pkg::CFG_RST;
  logic              tach_prev = 1'b1;
  logic [CNT_W-1:0]  ticks_since_edge = '0;
  logic [CNT_W-1:0]  period_hist [WIN] = '{default: '0};
  logic [SPEED_W-1:0] speed_now = '0;
  logic [DRIVE_W-1:0] drive_now = tmsc_pkg::DRIVE_RST;
  logic [PERIOD_W-1:0] ctrl_timer = '0;

  tick_reading_t pending_readings[$];

  tacho_median_speed_p_control dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .tach_level_i    (tach_level),
    .pop             (pop),
    .empty           (empty),
    .speed_value_o   (speed_value),
    .drive_level_o   (drive_level),
    .drive_updated_o (drive_updated),
    .edge_seen_o     (edge_seen),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------
  function automatic logic [CNT_W-1:0] median_period();
    int lt, le;
    for (int i = 0; i < WIN; i++) begin
      lt = 0;
      le = 0;
      for (int j = 0; j < WIN; j++) begin
        if (period_hist[j] < period_hist[i]) lt++;
        if (period_hist[j] <= period_hist[i]) le++;
      end
      if (lt <= WIN / 2 && le > WIN / 2) return period_hist[i];
    end
    return '0;
  endfunction

  task automatic predict_tick(input logic lvl);
    tick_reading_t r;
    logic [CNT_W-1:0] med;
    logic [GAIN_W-1:0] quot;
    longint err, prod, sum;
    r = '{default: '0};
    if (!tach_prev && lvl) begin
      for (int i = 0; i < WIN - 1; i++) period_hist[i] = period_hist[i + 1];
      period_hist[WIN - 1] = ticks_since_edge;
      med = median_period();
      if (med == '0) begin
        speed_now = '0;
      end else begin
        quot = shadow_cfg.speed_gain / med;
        speed_now = (quot > tmsc_pkg::SPEED_MAX) ? tmsc_pkg::SPEED_MAX : quot[SPEED_W-1:0];
      end
      ticks_since_edge = '0;
      r.rising = 1'b1;
    end
    if (ticks_since_edge != CNT_MAX) ticks_since_edge++;
    tach_prev = lvl;
    if (ctrl_timer == '0) begin
      if (ticks_since_edge > shadow_cfg.stall_limit) speed_now = '0;
      err  = longint'(shadow_cfg.speed_setpoint) - longint'(speed_now);
      prod = longint'(shadow_cfg.prop_gain) * err;
      // arithmetic shift floors, so negative steps round down
      sum  = longint'(drive_now) + (prod >>> 8);
      if (sum < 0) sum = 0;
      if (sum > longint'(shadow_cfg.drive_max)) sum = longint'(shadow_cfg.drive_max);
      drive_now = sum[DRIVE_W-1:0];
      r.updated = 1'b1;
    end
    if (int'(ctrl_timer) + 1 >= int'(shadow_cfg.control_period)) ctrl_timer = '0;
    else ctrl_timer++;
    r.speed     = speed_now;
    r.drive_lvl = drive_now[DRIVE_W-1:8];
    pending_readings.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
    if (mismatches < 20)
      $display("MISMATCH at %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_readings
    tick_reading_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected item, speed", -1, speed_value);
      end else begin
        want = pending_readings.pop_front();
        if (speed_value !== want.speed)
          report_mismatch("speed_value", want.speed, speed_value);
        if (drive_level !== want.drive_lvl)
          report_mismatch("drive_level", want.drive_lvl, drive_level);
        if (drive_updated !== want.updated)
          report_mismatch("drive_updated", want.updated, drive_updated);
        if (edge_seen !== want.rising)
          report_mismatch("edge_seen", want.rising, edge_seen);
      end
    end
  end

  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tacho_median_speed_p_control verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic set_idling(input idle_mode_e mode);
    send_idle_pct  = (mode == IDLE_SENDER)   ? 76 : (mode == IDLE_BOTH) ? 12 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 76 : (mode == IDLE_BOTH) ? 12 : 0;
  endtask

  task automatic send_tick(input logic lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push       <= 1'b1;
    tach_level <= lvl;
    do @(posedge clk_i); while (full);
    predict_tick(lvl);
  endtask

  // stop sending, let every reading come back and the back end go quiet
  task automatic settle();
    push <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      tmsc_pkg::REG_SPEED_GAIN:     shadow_cfg.speed_gain     = data[GAIN_W-1:0];
      tmsc_pkg::REG_SPEED_SETPOINT: shadow_cfg.speed_setpoint = data[SETPT_W-1:0];
      tmsc_pkg::REG_PROP_GAIN:      shadow_cfg.prop_gain      = data[KP_W-1:0];
      tmsc_pkg::REG_DRIVE_MAX:      shadow_cfg.drive_max      = data[DRIVE_W-1:0];
      tmsc_pkg::REG_STALL_LIMIT:    shadow_cfg.stall_limit    = data[LIMIT_W-1:0];
      tmsc_pkg::REG_CONTROL_PERIOD: shadow_cfg.control_period = data[PERIOD_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // random junk above the field so the write mask gets exercised
  function automatic logic [CFG_DAT_W-1:0] pad_junk(input logic [CFG_DAT_W-1:0] v,
                                                     input int w);
    logic [CFG_DAT_W-1:0] junk;
    junk = $urandom();
    if (w >= CFG_DAT_W) return v;
    return (junk << w) | v;
  endfunction

  task automatic program_regs(input logic [GAIN_W-1:0] gain, input logic [SETPT_W-1:0] setpt,
                              input logic [KP_W-1:0] kp, input logic [DRIVE_W-1:0] dmax,
                              input logic [LIMIT_W-1:0] stall, input logic [PERIOD_W-1:0] per);
    write_reg(tmsc_pkg::REG_SPEED_GAIN, gain);
    write_reg(tmsc_pkg::REG_SPEED_SETPOINT, pad_junk(setpt, SETPT_W));
    write_reg(tmsc_pkg::REG_PROP_GAIN, pad_junk(kp, KP_W));
    write_reg(tmsc_pkg::REG_DRIVE_MAX, pad_junk(dmax, DRIVE_W));
    write_reg(tmsc_pkg::REG_STALL_LIMIT, pad_junk(stall, LIMIT_W));
    write_reg(tmsc_pkg::REG_CONTROL_PERIOD, pad_junk(per, PERIOD_W));
  endtask

  // mostly clean square waves with jitter, some stalls, some random noise
  task automatic send_waveform(input int n_items);
    int sent, base, lo, hi, kind;
    sent = 0;
    base = $urandom_range(2, 24);
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      lo = 0;
      hi = 0;
      if (kind < 75) begin
        lo = base / 2 + $urandom_range(0, 2);
        hi = base - base / 2 + $urandom_range(0, 2);
      end else if (kind < 87) begin
        lo = $urandom_range(40, 150);
        hi = $urandom_range(1, 3);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_tick($urandom_range(0, 1));
          sent++;
        end
      end
      repeat (lo) begin
        send_tick(1'b0);
        sent++;
      end
      repeat (hi) begin
        send_tick(1'b1);
        sent++;
      end
      if ($urandom_range(0, 19) == 0) base = $urandom_range(2, 24);
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // reset values: first edges see a zero median, the third one saturates
  task automatic test_reset_defaults();
    logic [9:0] levels;
    levels = 10'b1011001010;
    set_idling(IDLE_NONE);
    for (int i = 0; i < 10; i++) send_tick(levels[i]);
    settle();
  endtask

  // zero gain, period zero cutting a running timer short, drive up to 0xFFFF
  task automatic test_zero_gain_and_upper_clamp();
    program_regs('0, '1, '1, '1, '1, '0);
    write_reg(REG_SPARE_A, $urandom());
    write_reg(REG_SPARE_B, $urandom());
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    settle();
  endtask

  // overflowing quotient against setpoint zero drives down to zero, then
  // a stall limit of zero and drive_max zero
  task automatic test_overflow_and_lower_clamp();
    program_regs('1, '0, '1, '1, '1, 16'd1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    settle();
    program_regs(32'd1, '1, '1, '0, '0, 16'd1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    settle();
  endtask

  task automatic test_random_traffic();
    logic [GAIN_W-1:0]   gain;
    logic [SETPT_W-1:0]  setpt;
    logic [KP_W-1:0]     kp;
    logic [DRIVE_W-1:0]  dmax;
    logic [LIMIT_W-1:0]  stall;
    logic [PERIOD_W-1:0] per;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        program_regs(32'd1, '0, '0, '0, '0, 16'd1);
      end else if (ph == 1) begin
        program_regs('1, '1, '1, '1, '1, '1);
      end else begin
        case ($urandom_range(0, 2))
          0:       gain = $urandom();
          1:       gain = $urandom_range(1, 5000);
          default: gain = $urandom_range(1000, 400000);
        endcase
        setpt = $urandom_range(0, 1) ? $urandom_range(0, 20'hFFFFF) : $urandom_range(0, 4000);
        kp    = $urandom_range(0, 4095);
        dmax  = ($urandom_range(0, 3) == 0) ? 16'hFFFF : $urandom_range(0, 65535);
        stall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20'hFFFFF)
                                            : $urandom_range(0, 100);
        per   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 12);
        program_regs(gain, setpt, kp, dmax, stall, per);
      end
      set_idling(idle_mode_e'(ph % 4));
      if (ph % 4 == 2) begin
        // sender waits for every outstanding reading midway
        send_waveform(110);
        push <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk_i);
        send_waveform(110);
      end else begin
        send_waveform(220);
      end
      settle();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_zero_gain_and_upper_clamp();
    test_overflow_and_lower_clamp();
    test_random_traffic();
    set_idling(IDLE_NONE);
    settle();
    if (mismatches == 0) begin
      $display("tacho_median_speed_p_control verification clean");
    end else begin
      $display("tacho_median_speed_p_control verification failed");
    end
    $finish;
  end

endmodule
